### src/tfpc_pkg.sv
// Shared types, codes and helper function of the transform feedback primitive counter.
package tfpc_pkg;

  localparam int CAPTURE_BUFFERS_DEF = 4;
  localparam int MAX_BUFS            = 4;

  localparam int STRIDE_W = 12;
  localparam int BYTES_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int OP_W     = 2;
  localparam int MODE_W   = 4;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 2;
  localparam int ADDED_W  = 31;
  localparam int TOTAL_W  = 48;
  localparam int VPP_W    = 2;
  localparam int KIND_W   = 2;

  localparam int DIV_STEPS = BYTES_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Reciprocal of three for 32-bit dividends: floor(x / 3) == (x * DIV3_MAGIC) >> 33.
  localparam logic [31:0] DIV3_MAGIC = 32'hAAAA_AAAB;
  localparam int          DIV3_SHIFT = 33;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_STRIDE0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES0  = 3'd4;

  localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ENUM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVOP = 2'd2;

  localparam logic [MODE_W-1:0] MODE_POINTS = 4'd0;
  localparam logic [MODE_W-1:0] MODE_LINES  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_LOOP   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_STRIP  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_TRIS   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_TSTRIP = 4'd5;
  localparam logic [MODE_W-1:0] MODE_FAN    = 4'd6;

  localparam logic [KIND_W-1:0] FB_POINTS = 2'd0;
  localparam logic [KIND_W-1:0] FB_LINES  = 2'd1;
  localparam logic [KIND_W-1:0] FB_TRIS   = 2'd2;

  typedef struct packed {
    logic load;
    logic decode;
    logic div_step;
    logic min_sel;
    logic fit;
    logic clamp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_clamp;
  } sts_t;

  function automatic logic [VPP_W-1:0] verts_per_prim(input logic [MODE_W-1:0] mode);
    logic [VPP_W-1:0] v;
    case (mode) inside
      MODE_LINES, MODE_LOOP, MODE_STRIP: v = 2'd2;
      MODE_TRIS, MODE_TSTRIP, MODE_FAN:  v = 2'd3;
      default:                           v = 2'd1;
    endcase
    return v;
  endfunction

endpackage

### src/tfpc_div.sv
// Restoring divider lane: 32-bit byte length over a 12-bit stride, one bit per step.
module tfpc_div (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic [tfpc_pkg::BYTES_W-1:0]  dividend,
  input  logic [tfpc_pkg::STRIDE_W-1:0] divisor,
  output logic [tfpc_pkg::BYTES_W-1:0]  quotient
);

  logic [tfpc_pkg::STRIDE_W-1:0] rem_r;
  logic [tfpc_pkg::STRIDE_W-1:0] rem_nxt;
  logic [tfpc_pkg::BYTES_W-1:0]  quo_r;
  logic [tfpc_pkg::BYTES_W-1:0]  quo_nxt;
  logic [tfpc_pkg::STRIDE_W-1:0] dvs_r;
  logic [tfpc_pkg::STRIDE_W:0]   trial;
  logic                          take;

  assign trial = {rem_r, quo_r[tfpc_pkg::BYTES_W-1]};
  assign take  = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt = take ? tfpc_pkg::STRIDE_W'(trial - {1'b0, dvs_r})
                   : trial[tfpc_pkg::STRIDE_W-1:0];
    quo_nxt = {quo_r[tfpc_pkg::BYTES_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;

endmodule

### src/tfpc_datapath.sv
// Datapath: configuration registers, capture state, divider lanes, clamp and totals.
module tfpc_datapath #(
  parameter int CAPTURE_BUFFERS = tfpc_pkg::CAPTURE_BUFFERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tfpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [tfpc_pkg::OP_W-1:0]       op,
  input  logic [tfpc_pkg::MODE_W-1:0]     prim_mode,
  input  logic [tfpc_pkg::COUNT_W-1:0]    vertex_count,
  input  logic                            has_geometry_stage,
  input  logic                            counts_primitives,
  input  tfpc_pkg::cmd_t                  cmd,
  output tfpc_pkg::sts_t                  sts,
  output logic [tfpc_pkg::STATUS_W-1:0]   status,
  output logic [tfpc_pkg::ADDED_W-1:0]    prims_added,
  output logic [tfpc_pkg::TOTAL_W-1:0]    prims_total,
  output logic [tfpc_pkg::TOTAL_W-1:0]    verts_total,
  output logic                            capture_active
);

  logic [tfpc_pkg::STRIDE_W-1:0] stride_r [CAPTURE_BUFFERS];
  logic [tfpc_pkg::BYTES_W-1:0]  bytes_r  [CAPTURE_BUFFERS];
  logic [tfpc_pkg::BYTES_W-1:0]  quo      [CAPTURE_BUFFERS];

  logic [tfpc_pkg::OP_W-1:0]    op_r;
  logic [tfpc_pkg::MODE_W-1:0]  mode_r;
  logic [tfpc_pkg::COUNT_W-1:0] cnt_r;
  logic                         geo_in_r;
  logic                         acct_r;

  logic                         active_r;
  logic [tfpc_pkg::KIND_W-1:0]  kind_r;
  logic                         gflag_r;
  logic [tfpc_pkg::TOTAL_W-1:0] ptot_r;
  logic [tfpc_pkg::TOTAL_W-1:0] vtot_r;

  logic [tfpc_pkg::STATUS_W-1:0] status_r;
  logic [tfpc_pkg::ADDED_W-1:0]  added_r;
  logic [tfpc_pkg::ADDED_W-1:0]  q3_r;
  logic [tfpc_pkg::ADDED_W-1:0]  prims_r;
  logic [tfpc_pkg::BYTES_W-1:0]  room_r;
  logic                          bounded_r;
  logic [63:0]                   prod_r;

  logic [tfpc_pkg::STATUS_W-1:0] out_status_r;
  logic [tfpc_pkg::ADDED_W-1:0]  out_added_r;
  logic [tfpc_pkg::TOTAL_W-1:0]  out_ptot_r;
  logic [tfpc_pkg::TOTAL_W-1:0]  out_vtot_r;
  logic                          out_active_r;

  logic [tfpc_pkg::VPP_W-1:0]    vpp;
  logic                          mode_fits;
  logic                          mismatch;
  logic                          prims_nz;
  logic [tfpc_pkg::STATUS_W-1:0] status_nxt;
  logic                          do_begin;
  logic                          do_end;
  logic [63:0]                   cnt_prod;
  logic [tfpc_pkg::ADDED_W-1:0]  assembled;
  logic [tfpc_pkg::BYTES_W-1:0]  cap;
  logic                          bounded;
  logic [tfpc_pkg::BYTES_W-1:0]  room;
  logic [tfpc_pkg::BYTES_W-1:0]  fit;
  logic [tfpc_pkg::ADDED_W-1:0]  prims_fin;
  logic [tfpc_pkg::ADDED_W+1:0]  vadd;
  logic [tfpc_pkg::TOTAL_W:0]    psum;
  logic [tfpc_pkg::TOTAL_W:0]    vsum;

  for (genvar i = 0; i < CAPTURE_BUFFERS; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stride_r[i] <= '0;
        bytes_r[i]  <= '0;
      end else if (cfg_we) begin
        if (cfg_index == tfpc_pkg::CFG_IDX_W'(tfpc_pkg::REG_STRIDE0 + i)) begin
          stride_r[i] <= cfg_wdata[tfpc_pkg::STRIDE_W-1:0];
        end
        if (cfg_index == tfpc_pkg::CFG_IDX_W'(tfpc_pkg::REG_BYTES0 + i)) begin
          bytes_r[i] <= cfg_wdata[tfpc_pkg::BYTES_W-1:0];
        end
      end
    end

    tfpc_div u_div (
      .clk      (clk),
      .start    (cmd.decode),
      .step     (cmd.div_step),
      .dividend (bytes_r[i]),
      .divisor  (stride_r[i]),
      .quotient (quo[i])
    );
  end

  assign vpp = tfpc_pkg::verts_per_prim(mode_r);

  always_comb begin
    case (kind_r)
      tfpc_pkg::FB_POINTS: mode_fits = (mode_r == tfpc_pkg::MODE_POINTS);
      tfpc_pkg::FB_LINES:  mode_fits = (mode_r >= tfpc_pkg::MODE_LINES) &&
                                       (mode_r <= tfpc_pkg::MODE_STRIP);
      tfpc_pkg::FB_TRIS:   mode_fits = (mode_r >= tfpc_pkg::MODE_TRIS) &&
                                       (mode_r <= tfpc_pkg::MODE_FAN);
      default:             mode_fits = 1'b0;
    endcase
  end

  assign mismatch = active_r && !gflag_r && !mode_fits;
  assign prims_nz = (mode_r <= tfpc_pkg::MODE_FAN) && !cnt_r[tfpc_pkg::COUNT_W-1] &&
                    (cnt_r[tfpc_pkg::COUNT_W-2:0] >= tfpc_pkg::ADDED_W'(vpp));

  always_comb begin
    status_nxt = tfpc_pkg::ST_OK;
    do_begin   = 1'b0;
    do_end     = 1'b0;
    unique case (op_r)
      tfpc_pkg::OP_BEGIN: begin
        if (mode_r != tfpc_pkg::MODE_POINTS && mode_r != tfpc_pkg::MODE_LINES &&
            mode_r != tfpc_pkg::MODE_TRIS) begin
          status_nxt = tfpc_pkg::ST_ENUM;
        end else if (active_r) begin
          status_nxt = tfpc_pkg::ST_INVOP;
        end else begin
          do_begin = 1'b1;
        end
      end
      tfpc_pkg::OP_END: begin
        if (!active_r) status_nxt = tfpc_pkg::ST_INVOP;
        else do_end = 1'b1;
      end
      tfpc_pkg::OP_DRAW: begin
        if (mismatch) status_nxt = tfpc_pkg::ST_INVOP;
      end
      default: status_nxt = tfpc_pkg::ST_ENUM;
    endcase
  end

  assign sts.need_clamp = (op_r == tfpc_pkg::OP_DRAW) && active_r && acct_r &&
                          !mismatch && prims_nz;

  assign cnt_prod = 64'(cnt_r[tfpc_pkg::COUNT_W-2:0]) * 64'(tfpc_pkg::DIV3_MAGIC);

  always_comb begin
    case (mode_r)
      tfpc_pkg::MODE_POINTS,
      tfpc_pkg::MODE_LOOP:   assembled = cnt_r[tfpc_pkg::ADDED_W-1:0];
      tfpc_pkg::MODE_LINES:  assembled = cnt_r[tfpc_pkg::ADDED_W-1:0] >> 1;
      tfpc_pkg::MODE_STRIP:  assembled = cnt_r[tfpc_pkg::ADDED_W-1:0] - 31'd1;
      tfpc_pkg::MODE_TRIS:   assembled = q3_r;
      tfpc_pkg::MODE_TSTRIP,
      tfpc_pkg::MODE_FAN:    assembled = cnt_r[tfpc_pkg::ADDED_W-1:0] - 31'd2;
      default:               assembled = '0;
    endcase
  end

  always_comb begin
    cap     = '0;
    bounded = 1'b0;
    for (int i = 0; i < CAPTURE_BUFFERS; i++) begin
      if (stride_r[i] != '0) begin
        if (!bounded || quo[i] < cap) cap = quo[i];
        bounded = 1'b1;
      end
    end
    room = ({16'b0, cap} > vtot_r) ? tfpc_pkg::BYTES_W'({16'b0, cap} - vtot_r) : '0;
  end

  always_comb begin
    case (vpp)
      2'd1:    fit = room_r;
      2'd2:    fit = room_r >> 1;
      default: fit = {1'b0, prod_r[63:tfpc_pkg::DIV3_SHIFT]};
    endcase
    prims_fin = (bounded_r && fit < {1'b0, prims_r}) ? fit[tfpc_pkg::ADDED_W-1:0] : prims_r;
    case (vpp)
      2'd1:    vadd = {2'b0, prims_fin};
      2'd2:    vadd = {1'b0, prims_fin, 1'b0};
      default: vadd = {2'b0, prims_fin} + {1'b0, prims_fin, 1'b0};
    endcase
    psum = {1'b0, ptot_r} + (tfpc_pkg::TOTAL_W + 1)'(prims_fin);
    vsum = {1'b0, vtot_r} + (tfpc_pkg::TOTAL_W + 1)'(vadd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      kind_r   <= tfpc_pkg::FB_POINTS;
      gflag_r  <= 1'b0;
      ptot_r   <= '0;
      vtot_r   <= '0;
    end else if (cmd.decode) begin
      if (do_begin) begin
        active_r <= 1'b1;
        kind_r   <= (mode_r == tfpc_pkg::MODE_POINTS) ? tfpc_pkg::FB_POINTS :
                    (mode_r == tfpc_pkg::MODE_LINES)  ? tfpc_pkg::FB_LINES  :
                                                        tfpc_pkg::FB_TRIS;
        gflag_r  <= geo_in_r;
        ptot_r   <= '0;
        vtot_r   <= '0;
      end else if (do_end) begin
        active_r <= 1'b0;
      end
    end else if (cmd.clamp) begin
      ptot_r <= psum[tfpc_pkg::TOTAL_W] ? tfpc_pkg::TOTAL_MAX : psum[tfpc_pkg::TOTAL_W-1:0];
      vtot_r <= vsum[tfpc_pkg::TOTAL_W] ? tfpc_pkg::TOTAL_MAX : vsum[tfpc_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op;
      mode_r   <= prim_mode;
      cnt_r    <= vertex_count;
      geo_in_r <= has_geometry_stage;
      acct_r   <= counts_primitives;
    end
    if (cmd.decode) begin
      status_r <= status_nxt;
      added_r  <= '0;
      q3_r     <= cnt_prod[tfpc_pkg::DIV3_SHIFT + tfpc_pkg::ADDED_W - 1:tfpc_pkg::DIV3_SHIFT];
    end
    if (cmd.min_sel) begin
      prims_r   <= assembled;
      room_r    <= room;
      bounded_r <= bounded;
    end
    if (cmd.fit) begin
      prod_r <= 64'(room_r) * 64'(tfpc_pkg::DIV3_MAGIC);
    end
    if (cmd.clamp) begin
      added_r <= prims_fin;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_added_r  <= added_r;
      out_ptot_r   <= ptot_r;
      out_vtot_r   <= vtot_r;
      out_active_r <= active_r;
    end
  end

  assign status         = out_status_r;
  assign prims_added    = out_added_r;
  assign prims_total    = out_ptot_r;
  assign verts_total    = out_vtot_r;
  assign capture_active = out_active_r;

endmodule

### src/tfpc_ctrl.sv
// Controller: sequences decode, division, clamp and result hand-off for each item.
module tfpc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  tfpc_pkg::sts_t sts,
  output tfpc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_MIN,
    S_FIT,
    S_CLAMP,
    S_DONE
  } state_t;

  state_t                          state_r;
  state_t                          state_nxt;
  logic [tfpc_pkg::DIV_CNT_W-1:0]  step_r;
  logic [tfpc_pkg::DIV_CNT_W-1:0]  step_nxt;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic                            out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        step_nxt   = '0;
        state_nxt  = sts.need_clamp ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == tfpc_pkg::DIV_CNT_W'(tfpc_pkg::DIV_STEPS - 1)) state_nxt = S_MIN;
      end
      S_MIN: begin
        cmd.min_sel = 1'b1;
        state_nxt   = S_FIT;
      end
      S_FIT: begin
        cmd.fit   = 1'b1;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

### src/transform_feedback_primitive_counter_unit.sv
// Top level of the transform feedback primitive counter: controller, datapath and ports.
//
//  Port group | Direction | tdata (low bit up)                              | tuser
//  in_        | slave     | prim_mode 4, vertex_count 32, has_geometry_stage | op 2
//             |           | 1, counts_primitives 1, zero pad 2               |
//  out_       | master    | prims_added 31, prims_total 48, verts_total 48,  | status 2
//             |           | capture_active 1                                 |
//  cfg_       | write     | index 0..3 stride_buf0..3, 4..7 bytes_buf0..3    | -
//
// A begin, end, rejected or unaccounted item goes from acceptance through S_DECODE and S_DONE to the
// next accept. An accounted draw that assembles primitives also passes S_DIV, the 32-step restoring
// divider in each capture buffer lane (all lanes run in parallel), then S_MIN, S_FIT and S_CLAMP.
// Reset is synchronous and clears the configuration registers, the capture state and the totals.
// A result held in the output register by out_tready low does not block the next item's
// acceptance; only the finish of that next item waits for the register to empty.
module transform_feedback_primitive_counter_unit #(
  parameter int CAPTURE_BUFFERS = tfpc_pkg::CAPTURE_BUFFERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [39:0]                     in_tdata,   // prim_mode, vertex_count, geo, acct
  input  logic [tfpc_pkg::OP_W-1:0]       in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [127:0]                    out_tdata,  // added, prims, verts, active
  output logic [tfpc_pkg::STATUS_W-1:0]   out_tuser,  // status
  input  logic                            cfg_we,
  input  logic [tfpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tfpc_pkg::cmd_t cmd;
  tfpc_pkg::sts_t sts;

  logic [tfpc_pkg::ADDED_W-1:0] prims_added;
  logic [tfpc_pkg::TOTAL_W-1:0] prims_total;
  logic [tfpc_pkg::TOTAL_W-1:0] verts_total;
  logic                         capture_active;

  tfpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tfpc_datapath #(
    .CAPTURE_BUFFERS (CAPTURE_BUFFERS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .op                 (in_tuser),
    .prim_mode          (in_tdata[3:0]),
    .vertex_count       (in_tdata[35:4]),
    .has_geometry_stage (in_tdata[36]),
    .counts_primitives  (in_tdata[37]),
    .cmd                (cmd),
    .sts                (sts),
    .status             (out_tuser),
    .prims_added        (prims_added),
    .prims_total        (prims_total),
    .verts_total        (verts_total),
    .capture_active     (capture_active)
  );

  assign out_tdata = {capture_active, verts_total, prims_total, prims_added};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while the previous one is still in work");

  a_added_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30:0] != '0 |-> out_tuser == tfpc_pkg::ST_OK)
    else $error("primitives recorded on a rejected item");

  a_added_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30:0] != '0 |-> out_tdata[127])
    else $error("primitives recorded while capture is inactive");

endmodule

### tb/tb_transform_feedback_primitive_counter_unit.sv
// Self-checking testbench for the transform feedback primitive counter: directed and random items.
`timescale 1ns / 1ps

module tb_transform_feedback_primitive_counter_unit;

  typedef logic [tfpc_pkg::OP_W-1:0]    op_t;
  typedef logic [tfpc_pkg::MODE_W-1:0]  mode_t;
  typedef logic [tfpc_pkg::COUNT_W-1:0] count_t;

  localparam op_t         OP_BAD    = 2'd3;
  localparam mode_t       MODE_ODD  = 4'd9;
  localparam mode_t       MODE_TOP  = 4'd15;
  localparam logic [63:0] SAT48     = 64'h0000_FFFF_FFFF_FFFF;
  localparam int          LIMIT     = 500000;
  localparam int          DRAIN     = 40;
  localparam int          PHASES    = 8;
  localparam int          PER_PHASE = 210;

  typedef struct packed {
    op_t    op;
    mode_t  mode;
    count_t count;
    logic   geo;
    logic   acct;
  } cmd_item_t;

  typedef struct packed {
    logic [tfpc_pkg::STATUS_W-1:0] status;
    logic [tfpc_pkg::ADDED_W-1:0]  added;
    logic [tfpc_pkg::TOTAL_W-1:0]  prims;
    logic [tfpc_pkg::TOTAL_W-1:0]  verts;
    logic                          active;
  } tally_t;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [39:0]                     in_tdata   = '0;
  op_t                             in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [127:0]                    out_tdata;
  logic [tfpc_pkg::STATUS_W-1:0]   out_tuser;
  logic                            cfg_we     = 1'b0;
  logic [tfpc_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [tfpc_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  transform_feedback_primitive_counter_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  cmd_item_t pending_cmds[$];
  tally_t    expected_tallies[$];
  cmd_item_t on_bus;
  bit        steady     = 1'b0;
  int        mismatches = 0;
  int        cycles     = 0;

  logic [tfpc_pkg::STRIDE_W-1:0] stride_cfg[tfpc_pkg::MAX_BUFS];
  logic [tfpc_pkg::BYTES_W-1:0]  bytes_cfg[tfpc_pkg::MAX_BUFS];
  logic [tfpc_pkg::STRIDE_W-1:0] next_stride[tfpc_pkg::MAX_BUFS];
  logic [tfpc_pkg::BYTES_W-1:0]  next_bytes[tfpc_pkg::MAX_BUFS];

  logic                        cap_active = 1'b0;
  logic [tfpc_pkg::KIND_W-1:0] cap_kind   = tfpc_pkg::FB_POINTS;
  logic                        cap_geo    = 1'b0;
  logic [63:0]                 prim_sum   = '0;
  logic [63:0]                 vert_sum   = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > SAT48) ? SAT48 : s;
  endfunction

  function automatic logic [63:0] prims_built(input mode_t mode, input longint n);
    if (n <= 0) return '0;
    case (mode)
      tfpc_pkg::MODE_POINTS: return 64'(n);
      tfpc_pkg::MODE_LINES:  return 64'(n / 2);
      tfpc_pkg::MODE_LOOP:   return (n >= 2) ? 64'(n) : '0;
      tfpc_pkg::MODE_STRIP:  return (n >= 2) ? 64'(n - 1) : '0;
      tfpc_pkg::MODE_TRIS:   return 64'(n / 3);
      tfpc_pkg::MODE_TSTRIP,
      tfpc_pkg::MODE_FAN:    return (n >= 3) ? 64'(n - 2) : '0;
      default:               return '0;
    endcase
  endfunction

  function automatic logic [63:0] verts_each(input mode_t mode);
    if (mode >= tfpc_pkg::MODE_LINES && mode <= tfpc_pkg::MODE_STRIP) return 64'd2;
    if (mode >= tfpc_pkg::MODE_TRIS && mode <= tfpc_pkg::MODE_FAN) return 64'd3;
    return 64'd1;
  endfunction

  function automatic bit kind_accepts(input mode_t mode);
    case (cap_kind)
      tfpc_pkg::FB_POINTS: return mode == tfpc_pkg::MODE_POINTS;
      tfpc_pkg::FB_LINES:  return mode >= tfpc_pkg::MODE_LINES && mode <= tfpc_pkg::MODE_STRIP;
      tfpc_pkg::FB_TRIS:   return mode >= tfpc_pkg::MODE_TRIS && mode <= tfpc_pkg::MODE_FAN;
      default:             return 1'b0;
    endcase
  endfunction

  // Updates the capture state for one item and returns the tally the block should report.
  function automatic tally_t account_item(input cmd_item_t it);
    tally_t      r;
    longint      n;
    logic [63:0] prims, vpp, cap, c, room;
    bit          bounded;
    int          i;
    r = '0;
    r.status = tfpc_pkg::ST_OK;
    case (it.op)
      tfpc_pkg::OP_BEGIN: begin
        if (it.mode != tfpc_pkg::MODE_POINTS && it.mode != tfpc_pkg::MODE_LINES &&
            it.mode != tfpc_pkg::MODE_TRIS) begin
          r.status = tfpc_pkg::ST_ENUM;
        end else if (cap_active) begin
          r.status = tfpc_pkg::ST_INVOP;
        end else begin
          cap_active = 1'b1;
          cap_kind   = (it.mode == tfpc_pkg::MODE_POINTS) ? tfpc_pkg::FB_POINTS :
                       (it.mode == tfpc_pkg::MODE_LINES) ? tfpc_pkg::FB_LINES :
                                                           tfpc_pkg::FB_TRIS;
          cap_geo    = it.geo;
          prim_sum   = '0;
          vert_sum   = '0;
        end
      end
      tfpc_pkg::OP_END: begin
        if (!cap_active) r.status = tfpc_pkg::ST_INVOP;
        else cap_active = 1'b0;
      end
      tfpc_pkg::OP_DRAW: begin
        if (cap_active && !cap_geo && !kind_accepts(it.mode)) begin
          r.status = tfpc_pkg::ST_INVOP;
        end else if (cap_active && it.acct) begin
          n     = longint'($signed(it.count));
          prims = prims_built(it.mode, n);
          vpp   = verts_each(it.mode);
          if (prims != 0) begin
            cap     = '0;
            bounded = 1'b0;
            for (i = 0; i < tfpc_pkg::CAPTURE_BUFFERS_DEF; i++) begin
              if (stride_cfg[i] != 0) begin
                c = 64'(bytes_cfg[i]) / 64'(stride_cfg[i]);
                if (!bounded || c < cap) cap = c;
                bounded = 1'b1;
              end
            end
            if (bounded) begin
              room = (cap > vert_sum) ? cap - vert_sum : '0;
              if (room / vpp < prims) prims = room / vpp;
            end
            prim_sum = sat_sum(prim_sum, prims);
            vert_sum = sat_sum(vert_sum, prims * vpp);
            r.added  = prims[tfpc_pkg::ADDED_W-1:0];
          end
        end
      end
      default: r.status = tfpc_pkg::ST_ENUM;
    endcase
    r.prims  = prim_sum[tfpc_pkg::TOTAL_W-1:0];
    r.verts  = vert_sum[tfpc_pkg::TOTAL_W-1:0];
    r.active = cap_active;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s at cycle %0d: got %0h, expected %0h", field, cycles, got, want);
    mismatches++;
  endtask

  task automatic enqueue(input op_t op, input mode_t mode, input count_t count,
                         input logic geo, input logic acct);
    cmd_item_t it;
    it.op    = op;
    it.mode  = mode;
    it.count = count;
    it.geo   = geo;
    it.acct  = acct;
    pending_cmds.push_back(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_tallies.size() != 0)
      @(negedge clk);
  endtask

  task automatic program_buffers();
    int i;
    for (i = 0; i < tfpc_pkg::MAX_BUFS; i++) begin
      @(posedge clk);
      cfg_we        <= 1'b1;
      cfg_index     <= tfpc_pkg::CFG_IDX_W'(tfpc_pkg::REG_STRIDE0 + i);
      cfg_wdata     <= tfpc_pkg::CFG_DATA_W'(next_stride[i]);
      stride_cfg[i]  = next_stride[i];
      @(posedge clk);
      cfg_index     <= tfpc_pkg::CFG_IDX_W'(tfpc_pkg::REG_BYTES0 + i);
      cfg_wdata     <= next_bytes[i];
      bytes_cfg[i]   = next_bytes[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic count_t pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(0, 300);
    if (r < 70) return $urandom_range(0, 10);
    if (r < 80) return $urandom;
    if (r < 90) return -$urandom_range(1, 1000);
    return $urandom_range(1000, 5000000);
  endfunction

  function automatic mode_t pick_draw_mode(input mode_t began);
    if ($urandom_range(9) == 0) return mode_t'($urandom_range(0, 15));
    if (began == tfpc_pkg::MODE_POINTS) return tfpc_pkg::MODE_POINTS;
    if (began == tfpc_pkg::MODE_LINES)
      return mode_t'($urandom_range(tfpc_pkg::MODE_LINES, tfpc_pkg::MODE_STRIP));
    return mode_t'($urandom_range(tfpc_pkg::MODE_TRIS, tfpc_pkg::MODE_FAN));
  endfunction

  // Mostly complete capture sessions with random draws, plus unstructured noise.
  task automatic queue_random(input int total);
    int    n, k, j;
    mode_t began;
    n = 0;
    while (n < total) begin
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(2))
          0:       began = tfpc_pkg::MODE_POINTS;
          1:       began = tfpc_pkg::MODE_LINES;
          default: began = tfpc_pkg::MODE_TRIS;
        endcase
        enqueue(tfpc_pkg::OP_BEGIN, began, $urandom, $urandom_range(3) == 0,
                1'($urandom_range(1)));
        k = $urandom_range(1, 25);
        for (j = 0; j < k; j++)
          enqueue(tfpc_pkg::OP_DRAW, pick_draw_mode(began), pick_count(),
                  1'($urandom_range(1)), $urandom_range(9) != 0);
        n += k + 1;
        if ($urandom_range(9) != 0) begin
          enqueue(tfpc_pkg::OP_END, mode_t'($urandom_range(0, 15)), $urandom,
                  1'($urandom_range(1)), 1'($urandom_range(1)));
          n++;
        end
      end else begin
        enqueue(op_t'($urandom_range(0, 3)), mode_t'($urandom_range(0, 15)), pick_count(),
                1'($urandom_range(1)), 1'($urandom_range(1)));
        n++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_tallies.push_back(account_item(on_bus));
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
          on_bus     = pending_cmds.pop_front();
          in_tdata  <= {2'b00, on_bus.acct, on_bus.geo, on_bus.count, on_bus.mode};
          in_tuser  <= on_bus.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tally_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_tallies.size() == 0) begin
          report_mismatch("unexpected result", {1'b0, out_tdata[126:64]}, 64'd0);
        end else begin
          want = expected_tallies.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", 64'(out_tuser), 64'(want.status));
          if (out_tdata[30:0] !== want.added)
            report_mismatch("prims_added", 64'(out_tdata[30:0]), 64'(want.added));
          if (out_tdata[78:31] !== want.prims)
            report_mismatch("prims_total", 64'(out_tdata[78:31]), 64'(want.prims));
          if (out_tdata[126:79] !== want.verts)
            report_mismatch("verts_total", 64'(out_tdata[126:79]), 64'(want.verts));
          if (out_tdata[127] !== want.active)
            report_mismatch("capture_active", 64'(out_tdata[127]), 64'(want.active));
        end
      end
      out_tready <= steady || ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int ph, i, r;
    for (i = 0; i < tfpc_pkg::MAX_BUFS; i++) begin
      stride_cfg[i] = '0;
      bytes_cfg[i]  = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: no buffer in use, so nothing is clamped.
    enqueue(tfpc_pkg::OP_END,   tfpc_pkg::MODE_POINTS, 32'd0, 1'b0, 1'b0);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_POINTS, 32'd50, 1'b0, 1'b1);
    enqueue(OP_BAD,             tfpc_pkg::MODE_POINTS, 32'd0, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_BEGIN, tfpc_pkg::MODE_LOOP, 32'd0, 1'b0, 1'b0);
    enqueue(tfpc_pkg::OP_BEGIN, MODE_TOP, 32'hFFFF_FFFF, 1'b1, 1'b1);
    enqueue(tfpc_pkg::OP_BEGIN, tfpc_pkg::MODE_POINTS, 32'd0, 1'b0, 1'b0);
    enqueue(tfpc_pkg::OP_BEGIN, tfpc_pkg::MODE_LINES, 32'd0, 1'b0, 1'b0);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_LINES, 32'd10, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_POINTS, 32'h7FFF_FFFF, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_POINTS, 32'h8000_0000, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_POINTS, 32'd0, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_POINTS, 32'd40, 1'b0, 1'b0);
    enqueue(tfpc_pkg::OP_END,   tfpc_pkg::MODE_POINTS, 32'd0, 1'b0, 1'b0);
    enqueue(tfpc_pkg::OP_BEGIN, tfpc_pkg::MODE_LINES, 32'd0, 1'b1, 1'b0);
    enqueue(tfpc_pkg::OP_DRAW,  MODE_ODD, 32'd100, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_LOOP, 32'd1, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_LOOP, 32'd5, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_STRIP, 32'd7, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_TRIS, 32'd10, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_TSTRIP, 32'd2, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_FAN, 32'd8, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_END,   tfpc_pkg::MODE_POINTS, 32'd0, 1'b0, 1'b0);
    enqueue(tfpc_pkg::OP_BEGIN, tfpc_pkg::MODE_TRIS, 32'd0, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_TSTRIP, 32'd9, 1'b0, 1'b1);
    enqueue(tfpc_pkg::OP_DRAW,  tfpc_pkg::MODE_POINTS, 32'd9, 1'b0, 1'b1);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      for (i = 0; i < tfpc_pkg::MAX_BUFS; i++) begin
        case (ph)
          0: begin
            next_stride[i] = '1;
            next_bytes[i]  = '1;
          end
          1: begin
            next_stride[i] = '0;
            next_bytes[i]  = $urandom;
          end
          2: begin
            next_stride[i] = (i == 2) ? 12'd1 : 12'd0;
            next_bytes[i]  = (i == 2) ? 32'd0 : $urandom;
          end
          default: begin
            r = $urandom_range(9);
            next_stride[i] = (r < 3) ? 12'd0 : (r == 9) ? 12'hFFF :
                             12'($urandom_range(1, 64));
            next_bytes[i]  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 40000);
          end
        endcase
      end
      program_buffers();
      steady = (ph == 4);
      queue_random(PER_PHASE);
    end

    wait_idle();
    steady = 1'b0;
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
src/tfpc_pkg.sv
src/tfpc_div.sv
src/tfpc_datapath.sv
src/tfpc_ctrl.sv
src/transform_feedback_primitive_counter_unit.sv
tb/tb_transform_feedback_primitive_counter_unit.sv
